@@ sv/assert_macros.svh @@
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, ck, rn, expr, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/cmtd_pkg.sv @@
// Types, constants and codes shared by the conflict mask task dispatcher.
package cmtd_pkg;

    // Sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int RUN_SLOTS   = 16;
    localparam int MASK_BITS   = 32;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RIDX_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int RCNT_W = $clog2(RUN_SLOTS + 1);

    // Fixed port field widths
    localparam int FUNC_W     = 2;
    localparam int TAG_W      = 8;
    localparam int IN_MASK_W  = 32;
    localparam int STATUS_W   = 3;
    localparam int OUT_CNT_W  = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQ   = 2'd0,
        FUNC_FETCH = 2'd1,
        FUNC_DONE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_QFULL   = 3'd1,
        ST_NONE    = 3'd2,
        ST_HALTED  = 3'd3,
        ST_NOTRUN  = 3'd4,
        ST_RFULL   = 3'd5
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } disp_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_stall;
    } dp_stat_t;

endpackage

@@ sv/conflict_mask_task_dispatcher_unit.sv @@
// Top level of the conflict mask task dispatcher.
//
// Requests enter on the s_ group: s_tuser carries the function (enqueue,
// fetch, complete, no-op), s_tdata the task tag and its conflict mask.
// Each request yields exactly one result on the m_ group with grant flag,
// granted tag, status code, queued count, running count and idle flag.
// A fetch grants the oldest queued task whose mask is disjoint from the
// union of all running masks (a zero mask always qualifies).
// halt is set through cfg_we/cfg_wdata; while set, fetches grant nothing.
// Sequence: the request is captured at the accepting edge, the queue is
// evaluated against the running table into registers, and the update is
// committed into the result register. A new request is taken in the cycle
// after commit; this is set by the capture/evaluate/commit sequence of the
// controller.
// A stalled receiver holds the result; the next request can be accepted
// while it waits, but its commit waits until the result register frees.
// Reset empties the queue and running table and clears halt.
module conflict_mask_task_dispatcher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_tag[7:0], conflict_mask[39:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // granted[0], granted_tag[8:1], status[11:9], queued_count[16:12],
    // running_count[21:17], idle[22], zero pad[23]
    output logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    cmtd_pkg::ctl_cmd_t cmd;
    cmtd_pkg::dp_stat_t stat;

    cmtd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    cmtd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_func   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ sv/cmtd_ctrl.sv @@
// Sequencer for the dispatcher: capture, evaluate, commit.
`include "assert_macros.svh"

module cmtd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cmtd_pkg::dp_stat_t stat,
    output cmtd_pkg::ctl_cmd_t cmd
);

    cmtd_pkg::disp_state_t state_reg;
    cmtd_pkg::disp_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmtd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cmtd_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cmtd_pkg::S_EVAL;
                end
            end
            cmtd_pkg::S_EVAL:
            begin
                state_next = cmtd_pkg::S_COMMIT;
            end
            cmtd_pkg::S_COMMIT:
            begin
                if (!stat.out_stall)
                begin
                    state_next = cmtd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cmtd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.eval    = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            cmtd_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            cmtd_pkg::S_EVAL:
            begin
                cmd.eval = 1'b1;
            end
            cmtd_pkg::S_COMMIT:
            begin
                cmd.commit = !stat.out_stall;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_capture_to_eval, clk, rst_n, cmd.capture, state_reg == cmtd_pkg::S_EVAL, "accepted request did not move to evaluation")

endmodule

@@ sv/cmtd_dp.sv @@
// Datapath: wait queue, running table, eligibility check and result register.
`include "assert_macros.svh"

module cmtd_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cmtd_pkg::ctl_cmd_t               cmd,
    output cmtd_pkg::dp_stat_t               stat,
    input  logic [cmtd_pkg::FUNC_W-1:0]      in_func,
    input  logic [cmtd_pkg::IN_DATA_W-1:0]   in_data,
    input  logic                             cfg_we,
    input  logic                             cfg_wdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cmtd_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int QD = cmtd_pkg::QUEUE_DEPTH;
    localparam int RS = cmtd_pkg::RUN_SLOTS;
    localparam int MB = cmtd_pkg::MASK_BITS;

    // Captured request
    cmtd_pkg::func_t                  func_reg;
    logic [cmtd_pkg::TAG_W-1:0]       tag_reg;
    logic [cmtd_pkg::IN_MASK_W-1:0]   mask_reg;

    logic                             halt_reg;

    // Wait queue, oldest at entry 0
    logic [cmtd_pkg::TAG_W-1:0]       q_tag_reg  [QD];
    logic [cmtd_pkg::TAG_W-1:0]       q_tag_next [QD];
    logic [MB-1:0]                    q_mask_reg [QD];
    logic [MB-1:0]                    q_mask_next[QD];
    logic [cmtd_pkg::QCNT_W-1:0]      q_cnt_reg;
    logic [cmtd_pkg::QCNT_W-1:0]      q_cnt_next;

    // Running table
    logic [cmtd_pkg::TAG_W-1:0]       r_tag_reg  [RS];
    logic [cmtd_pkg::TAG_W-1:0]       r_tag_next [RS];
    logic [MB-1:0]                    r_mask_reg [RS];
    logic [MB-1:0]                    r_mask_next[RS];
    logic [RS-1:0]                    r_valid_reg;
    logic [RS-1:0]                    r_valid_next;
    logic [cmtd_pkg::RCNT_W-1:0]      run_cnt_reg;
    logic [cmtd_pkg::RCNT_W-1:0]      run_cnt_next;

    // Evaluation results
    logic [MB-1:0]                    busy_union;
    logic [QD-1:0]                    elig_vec;
    logic [QD-1:0]                    elig_vec_reg;
    logic [RS-1:0]                    hit_vec;
    logic [RS-1:0]                    hit_vec_reg;
    logic [cmtd_pkg::RIDX_W-1:0]      free_idx;
    logic [cmtd_pkg::RIDX_W-1:0]      free_idx_reg;

    // Commit decisions
    logic [cmtd_pkg::QIDX_W-1:0]      sel_idx;
    logic [cmtd_pkg::RIDX_W-1:0]      hit_idx;
    logic                             grant;
    logic [cmtd_pkg::TAG_W-1:0]       gtag;
    cmtd_pkg::status_t                status;
    logic                             run_full;

    // Result register
    logic                             out_valid_reg;
    logic [cmtd_pkg::OUT_DATA_W-1:0]  out_data_reg;
    logic [cmtd_pkg::OUT_DATA_W-1:0]  out_data_next;

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= cmtd_pkg::func_t'(in_func);
            tag_reg  <= in_data[cmtd_pkg::TAG_W-1:0];
            mask_reg <= in_data[cmtd_pkg::TAG_W +: cmtd_pkg::IN_MASK_W];
        end
    end

    // Halt register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            halt_reg <= cfg_wdata;
        end
    end

    // Evaluation: union of running masks, eligible entries, free slot, tag hits
    always_comb
    begin
        busy_union = '0;
        for (int i = 0; i < RS; i++)
        begin
            if (r_valid_reg[i])
            begin
                busy_union = busy_union | r_mask_reg[i];
            end
        end
        for (int i = 0; i < QD; i++)
        begin
            elig_vec[i] = (cmtd_pkg::QCNT_W'(i) < q_cnt_reg)
                          && ((q_mask_reg[i] & busy_union) == '0);
        end
        free_idx = '0;
        for (int i = RS - 1; i >= 0; i--)
        begin
            if (!r_valid_reg[i])
            begin
                free_idx = cmtd_pkg::RIDX_W'(i);
            end
        end
        for (int i = 0; i < RS; i++)
        begin
            hit_vec[i] = r_valid_reg[i] && (r_tag_reg[i] == tag_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            elig_vec_reg <= elig_vec;
            hit_vec_reg  <= hit_vec;
            free_idx_reg <= free_idx;
        end
    end

    // Oldest eligible entry and lowest matching slot
    always_comb
    begin
        sel_idx = '0;
        for (int i = QD - 1; i >= 0; i--)
        begin
            if (elig_vec_reg[i])
            begin
                sel_idx = cmtd_pkg::QIDX_W'(i);
            end
        end
        hit_idx = '0;
        for (int i = RS - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = cmtd_pkg::RIDX_W'(i);
            end
        end
    end

    assign run_full = (run_cnt_reg == cmtd_pkg::RCNT_W'(RS));

    // Commit: next state of queue and table, and the result
    always_comb
    begin
        q_tag_next   = q_tag_reg;
        q_mask_next  = q_mask_reg;
        q_cnt_next   = q_cnt_reg;
        r_tag_next   = r_tag_reg;
        r_mask_next  = r_mask_reg;
        r_valid_next = r_valid_reg;
        run_cnt_next = run_cnt_reg;
        grant        = 1'b0;
        gtag         = '0;
        status       = cmtd_pkg::ST_OK;
        case (func_reg)
            cmtd_pkg::FUNC_ENQ:
            begin
                if (q_cnt_reg < cmtd_pkg::QCNT_W'(QD))
                begin
                    q_tag_next[q_cnt_reg[cmtd_pkg::QIDX_W-1:0]]  = tag_reg;
                    q_mask_next[q_cnt_reg[cmtd_pkg::QIDX_W-1:0]] = MB'(mask_reg);
                    q_cnt_next = q_cnt_reg + 1'b1;
                end
                else
                begin
                    status = cmtd_pkg::ST_QFULL;
                end
            end
            cmtd_pkg::FUNC_FETCH:
            begin
                if (halt_reg)
                begin
                    status = cmtd_pkg::ST_HALTED;
                end
                else if (run_full)
                begin
                    status = cmtd_pkg::ST_RFULL;
                end
                else if (elig_vec_reg == '0)
                begin
                    status = cmtd_pkg::ST_NONE;
                end
                else
                begin
                    grant = 1'b1;
                    gtag  = q_tag_reg[sel_idx];
                    r_tag_next[free_idx_reg]   = q_tag_reg[sel_idx];
                    r_mask_next[free_idx_reg]  = q_mask_reg[sel_idx];
                    r_valid_next[free_idx_reg] = 1'b1;
                    run_cnt_next = run_cnt_reg + 1'b1;
                    // close the gap behind the granted entry
                    for (int j = 0; j < QD - 1; j++)
                    begin
                        if (cmtd_pkg::QIDX_W'(j) >= sel_idx)
                        begin
                            q_tag_next[j]  = q_tag_reg[j + 1];
                            q_mask_next[j] = q_mask_reg[j + 1];
                        end
                    end
                    q_cnt_next = q_cnt_reg - 1'b1;
                end
            end
            cmtd_pkg::FUNC_DONE:
            begin
                if (hit_vec_reg != '0)
                begin
                    r_valid_next[hit_idx] = 1'b0;
                    run_cnt_next = run_cnt_reg - 1'b1;
                end
                else
                begin
                    status = cmtd_pkg::ST_NOTRUN;
                end
            end
            default:
            begin
                status = cmtd_pkg::ST_OK;
            end
        endcase
        out_data_next = {
            1'b0,
            ((q_cnt_next == '0) && (run_cnt_next == '0)),
            cmtd_pkg::OUT_CNT_W'(run_cnt_next),
            cmtd_pkg::OUT_CNT_W'(q_cnt_next),
            status,
            gtag,
            grant
        };
    end

    // Control state of queue and table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg   <= '0;
            r_valid_reg <= '0;
            run_cnt_reg <= '0;
        end
        else if (cmd.commit)
        begin
            q_cnt_reg   <= q_cnt_next;
            r_valid_reg <= r_valid_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

    // Payload storage of queue and table
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            q_tag_reg  <= q_tag_next;
            q_mask_reg <= q_mask_next;
            r_tag_reg  <= r_tag_next;
            r_mask_reg <= r_mask_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata        = out_data_reg;
    assign stat.out_stall = out_valid_reg && !m_tready;

    `ASSERT_ALWAYS(a_run_count, clk, rst_n, run_cnt_reg == cmtd_pkg::RCNT_W'($countones(r_valid_reg)), "running count out of step with valid bits")
    `ASSERT_ALWAYS(a_queue_bound, clk, rst_n, q_cnt_reg <= cmtd_pkg::QCNT_W'(QD), "queue count above depth")
    `ASSERT_IMPL(a_grant_free_slot, clk, rst_n, cmd.commit && grant, !r_valid_reg[free_idx_reg], "grant into an occupied running slot")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the conflict mask task dispatcher: a directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
    import cmtd_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int END_PAUSE      = 8;

    // Result layout on m_tdata, granted in bit 0
    typedef struct packed {
        logic       pad;
        logic       idle;
        logic [4:0] run_cnt;
        logic [4:0] queue_cnt;
        status_t    status;
        logic [7:0] grant_tag;
        logic       granted;
    } dispatch_result_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [31:0] mask;
    } task_entry_t;

    typedef enum logic [1:0] {
        HALT_KEEP,
        HALT_SET,
        HALT_CLEAR
    } halt_op_t;

    typedef struct {
        halt_op_t         halt_op;
        func_t            func;
        logic [7:0]       tag;
        logic [31:0]      mask;
        int               reps;
        bit               typed;
        dispatch_result_t result;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // task_tag[7:0], conflict_mask[39:8]
    logic [1:0]  s_tuser;     // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;     // granted, granted_tag, status, queued, running, idle, pad
    logic        cfg_we;
    logic        cfg_wdata;

    // Predictor state
    task_entry_t      wait_list[$];
    task_entry_t      run_slot[RUN_SLOTS];
    bit               run_busy[RUN_SLOTS];
    bit               halt_cfg;
    dispatch_result_t awaited_results[$];

    stim_row_t        directed_rows[$];
    bit               drv_typed;
    dispatch_result_t drv_typed_result;
    int               send_gap_pct   = 0;
    int               recv_stall_pct = 0;
    int               hold_req       = 0;
    int               hold_left      = 0;
    int               stuck_cycles   = 0;
    int               error_count    = 0;

    conflict_mask_task_dispatcher_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock, 2 ns period
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int running_total();
        int n;
        int i;
        n = 0;
        for (i = 0; i < RUN_SLOTS; i++)
            if (run_busy[i])
                n++;
        return n;
    endfunction

    // Apply one request to the predictor state and return the result it yields
    function automatic dispatch_result_t predict_dispatch(func_t f, logic [7:0] req_tag,
                                                          logic [31:0] req_mask);
        dispatch_result_t r;
        logic [31:0]      held;
        int               pick;
        int               i;
        int               n_run;
        r = '0;
        r.status = ST_OK;
        case (f)
            FUNC_ENQ:
                if (wait_list.size() >= QUEUE_DEPTH)
                    r.status = ST_QFULL;
                else
                    wait_list.insert(wait_list.size(), {req_tag, req_mask});
            FUNC_FETCH:
                if (halt_cfg)
                    r.status = ST_HALTED;
                else if (running_total() >= RUN_SLOTS)
                    r.status = ST_RFULL;
                else
                begin
                    // resources held by running tasks
                    held = '0;
                    for (i = 0; i < RUN_SLOTS; i++)
                        if (run_busy[i])
                            held |= run_slot[i].mask;
                    // oldest queued task that is disjoint from them
                    pick = -1;
                    for (i = 0; i < wait_list.size() && pick < 0; i++)
                        if ((wait_list[i].mask & held) == '0)
                            pick = i;
                    if (pick < 0)
                        r.status = ST_NONE;
                    else
                    begin
                        for (i = 0; i < RUN_SLOTS; i++)
                            if (!run_busy[i])
                                break;
                        run_slot[i] = wait_list[pick];
                        run_busy[i] = 1'b1;
                        r.granted   = 1'b1;
                        r.grant_tag = wait_list[pick].tag;
                        wait_list.delete(pick);
                    end
                end
            FUNC_DONE:
            begin
                // lowest slot holding the tag is freed
                r.status = ST_NOTRUN;
                for (i = 0; i < RUN_SLOTS; i++)
                    if (run_busy[i] && run_slot[i].tag == req_tag)
                    begin
                        run_busy[i] = 1'b0;
                        r.status = ST_OK;
                        break;
                    end
            end
            default: ;
        endcase
        n_run = running_total();
        r.queue_cnt = 5'(wait_list.size());
        r.run_cnt   = 5'(n_run);
        r.idle      = (wait_list.size() == 0) && (n_run == 0);
        return r;
    endfunction

    function automatic dispatch_result_t outcome(logic granted, logic [7:0] tag, status_t st,
                                                 int queued, int running);
        dispatch_result_t r;
        r = '0;
        r.granted   = granted;
        r.grant_tag = tag;
        r.status    = st;
        r.queue_cnt = 5'(queued);
        r.run_cnt   = 5'(running);
        r.idle      = (queued == 0) && (running == 0);
        return r;
    endfunction

    task automatic add_row(input halt_op_t op, input func_t f, input logic [7:0] tag,
                           input logic [31:0] mask, input int reps, input bit typed,
                           input dispatch_result_t result);
        stim_row_t row;
        row.halt_op = op;
        row.func    = f;
        row.tag     = tag;
        row.mask    = mask;
        row.reps    = reps;
        row.typed   = typed;
        row.result  = result;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // Accepted requests feed the predictor, accepted results are checked
    always @(posedge clk)
    begin : monitor
        dispatch_result_t seen;
        dispatch_result_t want;
        stuck_cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            stuck_cycles = 0;
            seen = dispatch_result_t'(m_tdata);
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result with none awaited: expected nothing, actual %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("granted", 32'(want.granted), 32'(seen.granted));
                check_field("granted_tag", 32'(want.grant_tag), 32'(seen.grant_tag));
                check_field("status", 32'(want.status), 32'(seen.status));
                check_field("queued_count", 32'(want.queue_cnt), 32'(seen.queue_cnt));
                check_field("running_count", 32'(want.run_cnt), 32'(seen.run_cnt));
                check_field("idle", 32'(want.idle), 32'(seen.idle));
                check_field("pad", 32'(want.pad), 32'(seen.pad));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            stuck_cycles = 0;
            want = predict_dispatch(func_t'(s_tuser), s_tdata[7:0], s_tdata[39:8]);
            if (drv_typed)
                want = drv_typed_result;
            awaited_results.insert(awaited_results.size(), want);
        end
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one request, starting at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input func_t f, input logic [7:0] tag, input logic [31:0] mask,
                                input bit typed, input dispatch_result_t typed_result);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {mask, tag};
        drv_typed        = typed;
        drv_typed_result = typed_result;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stop offering and wait for every awaited result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_halt(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        halt_cfg  = value;
    endtask

    // Random request, weighted in bursts that fill or drain the tables
    task automatic make_request(input int seq, output func_t f, output logic [7:0] tag,
                                output logic [31:0] mask);
        int roll;
        int enq_w;
        int fetch_w;
        int done_w;
        int busy_n;
        int k;
        int i;
        case ((seq / 48) % 3)
            0:
            begin
                enq_w = 35; fetch_w = 35; done_w = 25;
            end
            1:
            begin
                enq_w = 55; fetch_w = 35; done_w = 5;
            end
            default:
            begin
                enq_w = 15; fetch_w = 35; done_w = 45;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < enq_w)
            f = FUNC_ENQ;
        else if (roll < enq_w + fetch_w)
            f = FUNC_FETCH;
        else if (roll < enq_w + fetch_w + done_w)
            f = FUNC_DONE;
        else
            f = FUNC_NOP;

        // small tag pool gives duplicates
        tag = ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 11));
        // completions mostly name a running task
        if (f == FUNC_DONE && $urandom_range(0, 3) != 0)
        begin
            busy_n = running_total();
            if (busy_n > 0)
            begin
                k = $urandom_range(0, busy_n - 1);
                for (i = 0; i < RUN_SLOTS; i++)
                    if (run_busy[i])
                    begin
                        if (k == 0)
                            tag = run_slot[i].tag;
                        k--;
                    end
            end
        end

        case ($urandom_range(0, 11))
            0:       mask = '0;
            1:       mask = $urandom;
            2:       mask = '1;
            3, 4, 5, 6:
                mask = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            // crowded low bits: frequent conflicts
            default: mask = (32'd1 << $urandom_range(0, 7)) | (32'd1 << $urandom_range(0, 7));
        endcase
    endtask

    task automatic run_phase(input int n_items, input int gap_pct, input int stall_pct,
                             input bit halt_value, input bit squeeze);
        func_t       f;
        logic [7:0]  tag;
        logic [31:0] mask;
        int          k;
        drain_results();
        write_halt(halt_value);
        send_gap_pct = gap_pct;
        @(posedge clk);
        recv_stall_pct = stall_pct;
        if (squeeze)
            hold_req = SQUEEZE_CYCLES;
        @(negedge clk);
        for (k = 0; k < n_items; k++)
        begin
            // sender pauses midway until all results are back
            if (squeeze && k == n_items / 2)
                drain_results();
            make_request(k, f, tag, mask);
            send_request(f, tag, mask, 1'b0, '0);
        end
    endtask

    // Stimulus
    initial
    begin
        stim_row_t row;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_NOP;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        drv_typed = 1'b0;
        drv_typed_result = '0;
        halt_cfg  = 1'b0;
        foreach (run_busy[i])
            run_busy[i] = 1'b0;

        // halt     func        tag    mask        reps typed expected
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_NONE, 0, 0));
        add_row(HALT_KEEP, FUNC_DONE, 8'h55, 32'h0, 1, 1, outcome(0, 8'h00, ST_NOTRUN, 0, 0));
        add_row(HALT_KEEP, FUNC_NOP, 8'hff, 32'hffffffff, 1, 1,
                outcome(0, 8'h00, ST_OK, 0, 0));
        add_row(HALT_KEEP, FUNC_ENQ, 8'hff, 32'hffffffff, 1, 1,
                outcome(0, 8'h00, ST_OK, 1, 0));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(1, 8'hff, ST_OK, 0, 1));
        add_row(HALT_KEEP, FUNC_ENQ, 8'h00, 32'h1, 1, 1, outcome(0, 8'h00, ST_OK, 1, 1));
        add_row(HALT_KEEP, FUNC_ENQ, 8'h12, 32'h0, 1, 1, outcome(0, 8'h00, ST_OK, 2, 1));
        // zero mask passes an older blocked task
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(1, 8'h12, ST_OK, 1, 2));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_NONE, 1, 2));
        add_row(HALT_KEEP, FUNC_DONE, 8'hff, 32'h0, 1, 1, outcome(0, 8'h00, ST_OK, 1, 1));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(1, 8'h00, ST_OK, 0, 2));
        // duplicate tag
        add_row(HALT_KEEP, FUNC_ENQ, 8'h00, 32'h80000000, 1, 1,
                outcome(0, 8'h00, ST_OK, 1, 2));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(1, 8'h00, ST_OK, 0, 3));
        add_row(HALT_KEEP, FUNC_DONE, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_OK, 0, 2));
        add_row(HALT_KEEP, FUNC_DONE, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_OK, 0, 1));
        add_row(HALT_KEEP, FUNC_DONE, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_NOTRUN, 0, 1));
        // halted fetch
        add_row(HALT_SET, FUNC_ENQ, 8'ha5, 32'h5a5a5a5a, 1, 1,
                outcome(0, 8'h00, ST_OK, 1, 1));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_HALTED, 1, 1));
        add_row(HALT_CLEAR, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(1, 8'ha5, ST_OK, 0, 2));
        // queue full, then running table full
        add_row(HALT_KEEP, FUNC_ENQ, 8'h30, 32'h0, 16, 0, '0);
        add_row(HALT_KEEP, FUNC_ENQ, 8'h31, 32'h0, 1, 1, outcome(0, 8'h00, ST_QFULL, 16, 2));
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 14, 0, '0);
        add_row(HALT_KEEP, FUNC_FETCH, 8'h00, 32'h0, 1, 1, outcome(0, 8'h00, ST_RFULL, 2, 16));
        add_row(HALT_KEEP, FUNC_DONE, 8'h12, 32'h0, 1, 1, outcome(0, 8'h00, ST_OK, 2, 15));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table
        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.halt_op != HALT_KEEP)
            begin
                drain_results();
                write_halt(row.halt_op == HALT_SET);
            end
            repeat (row.reps)
                send_request(row.func, row.tag, row.mask, row.typed, row.result);
        end

        // Random phases: items, sender gap %, receiver stall %, halt, squeeze
        run_phase(400, 0, 0, 1'b0, 1'b0);
        run_phase(150, 88, 0, 1'b1, 1'b0);
        run_phase(250, 88, 0, 1'b0, 1'b0);
        run_phase(350, 0, 88, 1'b0, 1'b0);
        run_phase(350, 16, 16, 1'b0, 1'b1);

        drain_results();
        repeat (END_PAUSE) @(negedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
